>>> rtl/nearest_palette_color_search_top_defines.svh
// ----------------------------------------------------------------------------
// Nearest palette color search: assertion macros
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NPCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Types, constants and the level scaling table of the palette search.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned COMP_W     = 16;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned PBITS_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_BITS  = 2'd3;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RED_MAX_RST   = 3'd7;
  localparam logic [LEVEL_W-1:0] GREEN_MAX_RST = 3'd7;
  localparam logic [LEVEL_W-1:0] BLUE_MAX_RST  = 3'd3;
  localparam logic [PBITS_W-1:0] PAL_BITS_RST  = 4'd8;
  localparam logic [PBITS_W-1:0] PAL_BITS_MIN  = 4'd1;
  localparam logic [PBITS_W-1:0] PAL_BITS_MAX  = 4'd8;

  // Transaction modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pal_rgb_t;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [COMP_W-1:0]  entry_red;
    logic [COMP_W-1:0]  entry_green;
    logic [COMP_W-1:0]  entry_blue;
    logic               entry_usable;
    logic [LEVEL_W-1:0] level_red;
    logic [LEVEL_W-1:0] level_green;
    logic [LEVEL_W-1:0] level_blue;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  best_distance;
    logic               found;
  } out_item_t;

  // level*65535/max rounded down; max 0 acts as 1, level clamped to max
  function automatic logic [COMP_W-1:0] scale_level(input logic [LEVEL_W-1:0] level,
                                                    input logic [LEVEL_W-1:0] maxv);
    logic [LEVEL_W-1:0] m;
    logic [LEVEL_W-1:0] l;
    logic [COMP_W-1:0]  v;
    m = (maxv == 3'd0) ? 3'd1 : maxv;
    l = (level > m) ? m : level;
    case ({m, l})
      {3'd2, 3'd1}: v = 16'd32767;
      {3'd3, 3'd1}: v = 16'd21845;
      {3'd3, 3'd2}: v = 16'd43690;
      {3'd4, 3'd1}: v = 16'd16383;
      {3'd4, 3'd2}: v = 16'd32767;
      {3'd4, 3'd3}: v = 16'd49151;
      {3'd5, 3'd1}: v = 16'd13107;
      {3'd5, 3'd2}: v = 16'd26214;
      {3'd5, 3'd3}: v = 16'd39321;
      {3'd5, 3'd4}: v = 16'd52428;
      {3'd6, 3'd1}: v = 16'd10922;
      {3'd6, 3'd2}: v = 16'd21845;
      {3'd6, 3'd3}: v = 16'd32767;
      {3'd6, 3'd4}: v = 16'd43690;
      {3'd6, 3'd5}: v = 16'd54612;
      {3'd7, 3'd1}: v = 16'd9362;
      {3'd7, 3'd2}: v = 16'd18724;
      {3'd7, 3'd3}: v = 16'd28086;
      {3'd7, 3'd4}: v = 16'd37448;
      {3'd7, 3'd5}: v = 16'd46810;
      {3'd7, 3'd6}: v = 16'd56172;
      default: v = (l == m) ? 16'd65535 : 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/npcs_store.sv
// ----------------------------------------------------------------------------
// npcs_store
// Palette memory: color RAM with registered read plus per-entry usable flags.
// ----------------------------------------------------------------------------
module npcs_store import npcs_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  pal_rgb_t                   wr_rgb_i,
  input  logic                       wr_usable_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output pal_rgb_t                   rd_rgb_o,
  output logic                       rd_usable_o
);

  pal_rgb_t             rgb_mem [ENTRIES];
  logic [ENTRIES-1:0]   usable_q;
  pal_rgb_t             rd_rgb_q;
  logic                 rd_usable_q;

  // Color RAM, one write and one read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rgb_mem[wr_addr_i] <= wr_rgb_i;
    end
    if (rd_en_i) begin
      rd_rgb_q    <= rgb_mem[rd_addr_i];
      rd_usable_q <= usable_q[rd_addr_i];
    end
  end

  // Usable flags, cleared at reset so an unwritten entry is never chosen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= '0;
    end else if (wr_en_i) begin
      usable_q[wr_addr_i] <= wr_usable_i;
    end
  end

  assign rd_rgb_o    = rd_rgb_q;
  assign rd_usable_o = rd_usable_q;

endmodule

>>> rtl/npcs_scan.sv
// ----------------------------------------------------------------------------
// npcs_scan
// Scan sequencer: walks the palette one entry per cycle, computes the
// Manhattan distance and keeps the running minimum.
// ----------------------------------------------------------------------------
module npcs_scan import npcs_pkg::*; #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  pal_rgb_t                   tgt_i,
  input  logic [$clog2(ENTRIES)-1:0] last_idx_i,
  output logic                       busy_o,
  output logic                       rd_en_o,
  output logic [$clog2(ENTRIES)-1:0] rd_addr_o,
  input  pal_rgb_t                   rd_rgb_i,
  input  logic                       rd_usable_i,
  output logic                       res_valid_o,
  output out_item_t                  res_o,
  input  logic                       res_take_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  addr_q, last_q, idx1_q, idx2_q, best_idx_q, last_near_q;
  pal_rgb_t          tgt_q;
  logic              rd_v_q, cmp_v_q, found_q;
  logic [DIST_W-1:0] dist_d, dist_q, best_q;
  logic [COMP_W-1:0] ad_r, ad_g, ad_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SCAN;
      ST_SCAN:  if (addr_q == last_q) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_v_q && !cmp_v_q) state_d = ST_DONE;
      ST_DONE:  if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Distance of the entry just read from the target
  always_comb begin
    ad_r   = (rd_rgb_i.red   > tgt_q.red)   ? rd_rgb_i.red   - tgt_q.red
                                            : tgt_q.red   - rd_rgb_i.red;
    ad_g   = (rd_rgb_i.green > tgt_q.green) ? rd_rgb_i.green - tgt_q.green
                                            : tgt_q.green - rd_rgb_i.green;
    ad_b   = (rd_rgb_i.blue  > tgt_q.blue)  ? rd_rgb_i.blue  - tgt_q.blue
                                            : tgt_q.blue  - rd_rgb_i.blue;
    dist_d = DIST_W'(ad_r) + DIST_W'(ad_g) + DIST_W'(ad_b);
  end

  // Control: state, pipeline valids, best match, last answer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      addr_q      <= '0;
      last_near_q <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_SCAN);
      cmp_v_q <= rd_v_q && rd_usable_i;
      if (state_q == ST_IDLE && start_i) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (state_q == ST_SCAN) begin
          addr_q <= addr_q + 1'b1;
        end
        // strict compare keeps the lowest index on ties
        if (cmp_v_q && (!found_q || dist_q < best_q)) begin
          found_q <= 1'b1;
        end
      end
      if (state_q == ST_DONE && res_take_i && found_q) begin
        last_near_q <= best_idx_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      tgt_q  <= tgt_i;
      last_q <= last_idx_i;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    dist_q <= dist_d;
    if (cmp_v_q && (!found_q || dist_q < best_q)) begin
      best_q     <= dist_q;
      best_idx_q <= idx2_q;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign rd_en_o     = (state_q == ST_SCAN);
  assign rd_addr_o   = addr_q;
  assign res_valid_o = (state_q == ST_DONE);

  // No usable entry repeats the previous answer with zero distance
  always_comb begin
    res_o.found         = found_q;
    res_o.nearest_index = found_q ? INDEX_W'(best_idx_q) : INDEX_W'(last_near_q);
    res_o.best_distance = found_q ? best_q : '0;
  end

endmodule

>>> rtl/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Nearest palette color search by Manhattan distance over a loaded palette.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_stall_o/in_data_i): a load transaction writes
// one palette entry and returns nothing. A query transaction scales the cube
// levels by the configured maxima and scans entries 0 .. 2**palette_bits-1,
// one per cycle through the palette RAM read port, and keeps the input
// stalled while it runs. The result appears on the output channel
// (out_valid_o/out_stall_i/out_data_o) from an output register. A finished
// result waits in the scanner while the output register is still held by a
// stalled receiver; the input stays stalled until it moves on.
// Configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i) is written in one cycle and
// must change only while no query is in flight.
// Reset clears the registers to their defaults, marks every palette entry
// unusable and sets the repeated answer to index zero; no clearing pass runs.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned SPAN_W = INDEX_W + 1;

  logic [LEVEL_W-1:0] red_max_q, green_max_q, blue_max_q;
  logic [PBITS_W-1:0] pal_bits_q, bits_eff;
  logic [SPAN_W-1:0]  span;
  logic [IDX_W-1:0]   last_idx;
  logic               in_acc, wr_en, start, busy;
  logic               rd_en, rd_usable, res_valid, res_take;
  logic [IDX_W-1:0]   rd_addr;
  pal_rgb_t           wr_rgb, tgt, rd_rgb;
  out_item_t          res;
  logic               out_valid_q;
  out_item_t          out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= RED_MAX_RST;
      green_max_q <= GREEN_MAX_RST;
      blue_max_q  <= BLUE_MAX_RST;
      pal_bits_q  <= PAL_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RED_MAX:   red_max_q   <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_GREEN_MAX: green_max_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_BLUE_MAX:  blue_max_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PAL_BITS:  pal_bits_q  <= cfg_wdata_i[PBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and decode
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (in_data_i.mode == MODE_QUERY);
  assign wr_en      = in_acc && (in_data_i.mode == MODE_LOAD) &&
                      (SPAN_W'(in_data_i.entry_index) < SPAN_W'(PALETTE_ENTRIES));

  assign wr_rgb.red   = in_data_i.entry_red;
  assign wr_rgb.green = in_data_i.entry_green;
  assign wr_rgb.blue  = in_data_i.entry_blue;

  // Query targets and scan length
  always_comb begin
    tgt.red   = scale_level(in_data_i.level_red,   red_max_q);
    tgt.green = scale_level(in_data_i.level_green, green_max_q);
    tgt.blue  = scale_level(in_data_i.level_blue,  blue_max_q);
    if (pal_bits_q < PAL_BITS_MIN) begin
      bits_eff = PAL_BITS_MIN;
    end else if (pal_bits_q > PAL_BITS_MAX) begin
      bits_eff = PAL_BITS_MAX;
    end else begin
      bits_eff = pal_bits_q;
    end
    span = SPAN_W'(1) << bits_eff;
    if (span > SPAN_W'(PALETTE_ENTRIES)) begin
      span = SPAN_W'(PALETTE_ENTRIES);
    end
    last_idx = IDX_W'(span - SPAN_W'(1));
  end

  npcs_store #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (in_data_i.entry_index[IDX_W-1:0]),
    .wr_rgb_i    (wr_rgb),
    .wr_usable_i (in_data_i.entry_usable),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_rgb_o    (rd_rgb),
    .rd_usable_o (rd_usable)
  );

  npcs_scan #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .tgt_i       (tgt),
    .last_idx_i  (last_idx),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_rgb_i    (rd_rgb),
    .rd_usable_i (rd_usable),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // Output register
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/npcs_checker.sv
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level checks of the palette search, attached to the top by bind.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_search_top_defines.svh"

module npcs_checker import npcs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input in_item_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  // Held result stays put while the receiver stalls
  `NPCS_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "output changed while stalled")

  // A miss reports zero distance
  `NPCS_ASSERT_NOW(a_miss_dist, out_valid_i && !out_data_i.found, out_data_i.best_distance == '0, "miss with nonzero distance")

  // A query occupies the scanner on the following cycle
  `NPCS_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_i && in_data_i.mode == MODE_QUERY, in_stall_i, "query did not start a scan")

  // A load completes in its own cycle
  `NPCS_ASSERT_NEXT(a_load_free, in_valid_i && !in_stall_i && in_data_i.mode == MODE_LOAD, !in_stall_i, "load stalled the input")

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
